FILE: rtl/wcrb_pkg.sv
// Shared types, constants and helper functions for the wireless controller
// register block. No dependencies.

package wcrb_pkg;

  // Store geometry
  localparam int REG_BYTES     = 4096;
  localparam int RAM_BYTES_DEF = 8192;
  localparam int BB_REGS       = 256;
  localparam int LANES         = 4;
  localparam int QUEUE_DEPTH   = 2;

  // Normalised access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Operations decided by the front end
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_MEM_RD    = 4'd1;
  localparam logic [3:0] OP_MEM_WR    = 4'd2;
  localparam logic [3:0] OP_REG_RD    = 4'd3;
  localparam logic [3:0] OP_UNMAP_RD  = 4'd4;
  localparam logic [3:0] OP_WR_PWR    = 4'd5;
  localparam logic [3:0] OP_WR_CMD    = 4'd6;
  localparam logic [3:0] OP_WR_WLATCH = 4'd7;
  localparam logic [3:0] OP_WR_MODE   = 4'd8;
  localparam logic [3:0] OP_WR_BBP    = 4'd9;

  // Sources for named register reads
  localparam logic [2:0] RS_ZERO   = 3'd0;
  localparam logic [2:0] RS_PWR    = 3'd1;
  localparam logic [2:0] RS_RLATCH = 3'd2;
  localparam logic [2:0] RS_MODE   = 3'd3;
  localparam logic [2:0] RS_BBP    = 3'd4;

  // Named register offsets
  localparam logic [11:0] OFF_PWR       = 12'h03C;
  localparam logic [11:0] OFF_PWR_HI    = 12'h03D;
  localparam logic [11:0] OFF_BB_CMD    = 12'h158;
  localparam logic [11:0] OFF_BB_WLATCH = 12'h15A;
  localparam logic [11:0] OFF_BB_RLATCH = 12'h15C;
  localparam logic [11:0] OFF_BB_RL_B1  = 12'h15D;
  localparam logic [11:0] OFF_BB_RL_B2  = 12'h15E;
  localparam logic [11:0] OFF_BB_RL_B3  = 12'h15F;
  localparam logic [11:0] OFF_BB_MODE   = 12'h160;
  localparam logic [11:0] OFF_BB_MODE_H = 12'h161;
  localparam logic [11:0] OFF_BB_POWER  = 12'h168;
  localparam logic [11:0] OFF_BB_POW_H  = 12'h169;

  // Write masks
  localparam logic [15:0] MODE_MASK = 16'h4100;
  localparam logic [15:0] BBP_MASK  = 16'h800F;

  // Baseband serial port command opcodes and fixed read-back values
  localparam logic [3:0] BB_CMD_WRITE = 4'd5;
  localparam logic [3:0] BB_CMD_READ  = 4'd6;
  localparam logic [7:0] BB_IDX_ID    = 8'h00;
  localparam logic [7:0] BB_IDX_4D    = 8'h4D;
  localparam logic [7:0] BB_IDX_5D    = 8'h5D;
  localparam logic [7:0] BB_IDX_64    = 8'h64;
  localparam logic [7:0] BB_VAL_ID    = 8'h6D;
  localparam logic [7:0] BB_VAL_4D    = 8'h00;
  localparam logic [7:0] BB_VAL_5D    = 8'h01;
  localparam logic [7:0] BB_VAL_64    = 8'hFF;

  // One classified access as it sits in the queue
  typedef struct packed {
    logic [3:0]  op;
    logic        ram;    // packet RAM rather than generic register store
    logic [1:0]  size;
    logic [2:0]  rsrc;
    logic        rhi;    // take the upper byte of the named register
    logic [14:0] addr;
    logic [31:0] data;   // already masked to the access size
  } acc_t;

  function automatic logic [31:0] size_mask(input logic [1:0] size);
    logic [31:0] m;
    unique case (size)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_HALF: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic bb_writable(input logic [7:0] k);
    return (k >= 8'h01 && k <= 8'h0C) || (k >= 8'h13 && k <= 8'h15) ||
           (k >= 8'h1B && k <= 8'h26) || (k >= 8'h28 && k <= 8'h4C) ||
           (k >= 8'h4E && k <= 8'h5C) || (k >= 8'h62 && k <= 8'h63) ||
           k == 8'h65 || (k >= 8'h67 && k <= 8'h68);
  endfunction

  function automatic logic [7:0] bb_read_value(input logic [7:0] k, input logic [7:0] stored);
    logic [7:0] v;
    priority if (k == BB_IDX_ID) v = BB_VAL_ID;
    else if (k == BB_IDX_4D)     v = BB_VAL_4D;
    else if (k == BB_IDX_5D)     v = BB_VAL_5D;
    else if (k == BB_IDX_64)     v = BB_VAL_64;
    else if (bb_writable(k))     v = stored;
    else                         v = 8'h00;
    return v;
  endfunction

endpackage

FILE: rtl/wcrb_if.sv
// Valid/ready channel interfaces for bus requests and read responses.
// No dependencies.

interface wcrb_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  access_size;
  logic [14:0] address;
  logic [31:0] write_data;

  modport source (output valid, operation, access_size, address, write_data, input ready);
  modport sink   (input valid, operation, access_size, address, write_data, output ready);
endinterface

interface wcrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

FILE: rtl/wcrb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.

module wcrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/wcrb_front.sv
// Front end: takes bus requests and classifies them into queue entries.
// Depends on wcrb_pkg and wcrb_req_if.

module wcrb_front import wcrb_pkg::*; (
  wcrb_req_if.sink req,
  input  logic     busy,
  output logic     push_valid,
  input  logic     push_ready,
  output acc_t     push_data
);

  logic [1:0]  size;
  logic [2:0]  space;
  logic        in_regs;
  logic        in_ram;
  logic [11:0] off;

  assign req.ready  = push_ready && !busy;
  assign push_valid = req.valid && !busy;

  always_comb begin
    size    = (req.access_size == SZ_BYTE) ? SZ_BYTE :
              (req.access_size == SZ_HALF) ? SZ_HALF : SZ_WORD;
    space   = req.address[14:12];
    in_regs = (space == 3'd0) || (space == 3'd1) || (space == 3'd6) || (space == 3'd7);
    in_ram  = (space == 3'd4) || (space == 3'd5);
    off     = req.address[11:0];

    push_data      = '0;
    push_data.size = size;
    push_data.addr = req.address;
    push_data.data = req.write_data & size_mask(size);
    push_data.ram  = in_ram;
    push_data.op   = OP_NOP;

    if (req.operation) begin
      priority if (size == SZ_BYTE || !(in_regs || in_ram)) push_data.op = OP_NOP;
      else if (in_ram)                                    push_data.op = OP_MEM_WR;
      else if (off == OFF_PWR)                            push_data.op = OP_WR_PWR;
      else if (size == SZ_HALF && off == OFF_BB_CMD)      push_data.op = OP_WR_CMD;
      else if (size == SZ_HALF && off == OFF_BB_WLATCH)   push_data.op = OP_WR_WLATCH;
      else if (size == SZ_HALF && off == OFF_BB_MODE)     push_data.op = OP_WR_MODE;
      else if (size == SZ_HALF && off == OFF_BB_POWER)    push_data.op = OP_WR_BBP;
      else                                                push_data.op = OP_MEM_WR;
    end else if (in_ram) begin
      push_data.op = OP_MEM_RD;
    end else if (!in_regs) begin
      push_data.op = OP_UNMAP_RD;
    end else begin
      push_data.op = OP_REG_RD;
      unique case (size)
        SZ_BYTE: begin
          unique case (off)
            OFF_PWR:       push_data.rsrc = RS_PWR;
            OFF_PWR_HI: begin
              push_data.rsrc = RS_PWR;
              push_data.rhi  = 1'b1;
            end
            OFF_BB_RLATCH: push_data.rsrc = RS_RLATCH;
            OFF_BB_RL_B1,
            OFF_BB_RL_B2,
            OFF_BB_RL_B3:  push_data.rsrc = RS_ZERO;
            OFF_BB_MODE:   push_data.rsrc = RS_MODE;
            OFF_BB_MODE_H: begin
              push_data.rsrc = RS_MODE;
              push_data.rhi  = 1'b1;
            end
            OFF_BB_POWER:  push_data.rsrc = RS_BBP;
            OFF_BB_POW_H: begin
              push_data.rsrc = RS_BBP;
              push_data.rhi  = 1'b1;
            end
            default:       push_data.op = OP_MEM_RD;
          endcase
        end
        SZ_HALF: begin
          unique case (off)
            OFF_PWR:       push_data.rsrc = RS_PWR;
            OFF_BB_RLATCH: push_data.rsrc = RS_RLATCH;
            OFF_BB_RL_B2:  push_data.rsrc = RS_ZERO;
            OFF_BB_MODE:   push_data.rsrc = RS_MODE;
            OFF_BB_POWER:  push_data.rsrc = RS_BBP;
            default:       push_data.op = OP_MEM_RD;
          endcase
        end
        default: begin
          if (off == OFF_PWR) begin
            push_data.rsrc = RS_PWR;
          end else begin
            push_data.op = OP_MEM_RD;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/wcrb_queue.sv
// Small FIFO of classified accesses between the front and back ends.
// Depends on wcrb_pkg.

module wcrb_queue import wcrb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  acc_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output acc_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  acc_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/wcrb_back.sv
// Back end: executes queued accesses against the registers and the byte-lane
// stores, assembles read data and holds the response register.
// Depends on wcrb_pkg, wcrb_rsp_if and wcrb_ram.

module wcrb_back import wcrb_pkg::*; #(
  parameter int RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  output logic     q_ready,
  input  acc_t     q_data,
  output logic     busy,
  wcrb_rsp_if.source rsp
);

  localparam int REG_AW   = $clog2(REG_BYTES);
  localparam int RAM_AW   = $clog2(RAM_BYTES);
  localparam int REG_ROWS = REG_BYTES / LANES;
  localparam int RAM_ROWS = RAM_BYTES / LANES;
  localparam int REG_RW   = REG_AW - 2;
  localparam int RAM_RW   = RAM_AW - 2;
  localparam int BB_AW    = $clog2(BB_REGS);
  localparam int CLR_ROWS = (RAM_ROWS > REG_ROWS) ? RAM_ROWS : REG_ROWS;
  localparam int CLR_W    = $clog2(CLR_ROWS);

  // Clearing pass
  logic             clr_busy;
  logic [CLR_W-1:0] clr_row;
  logic             clr_reg;
  logic             clr_ram;
  logic             clr_bb;

  // Architectural registers
  logic [15:0] power_state;
  logic [7:0]  rlatch;
  logic [7:0]  wlatch;
  logic [15:0] bb_mode;
  logic [15:0] bb_pwr;

  // Issue stage
  logic        fire;
  acc_t        e;
  logic [3:0]  e_cmd;
  logic [1:0]  lane_i   [LANES];
  logic        lane_on  [LANES];
  logic [REG_RW-1:0] reg_row [LANES];
  logic [RAM_RW-1:0] ram_row [LANES];
  logic [7:0]  lane_wb  [LANES];

  // Lane memory ports
  logic              reg_we    [LANES];
  logic              reg_re    [LANES];
  logic [REG_RW-1:0] reg_addr  [LANES];
  logic [7:0]        reg_wdata [LANES];
  logic [7:0]        reg_rdata [LANES];
  logic              ram_we    [LANES];
  logic              ram_re    [LANES];
  logic [RAM_RW-1:0] ram_addr  [LANES];
  logic [7:0]        ram_wdata [LANES];
  logic [7:0]        ram_rdata [LANES];
  logic              bb_we;
  logic              bb_re;
  logic [BB_AW-1:0]  bb_addr;
  logic [7:0]        bb_wdata;
  logic [7:0]        bb_rdata;

  // Read-data stage and response register
  logic        p_valid;
  acc_t        p_acc;
  logic        p_move;
  logic [31:0] p_word;
  logic [15:0] p_reg;
  logic [31:0] p_result;
  logic        out_valid;
  logic [31:0] out_data;

  assign busy  = clr_busy;
  assign e     = q_data;
  assign e_cmd = e.data[15:12];

  assign clr_reg = clr_busy && ({1'b0, clr_row} < (CLR_W + 1)'(REG_ROWS));
  assign clr_ram = clr_busy && ({1'b0, clr_row} < (CLR_W + 1)'(RAM_ROWS));
  assign clr_bb  = clr_busy && ({1'b0, clr_row} < (CLR_W + 1)'(BB_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == CLR_W'(CLR_ROWS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign p_move  = p_valid && (!out_valid || rsp.ready);
  assign q_ready = !clr_busy && (!p_valid || p_move);
  assign fire    = q_valid && q_ready;

  // Byte lane mapping: lane j carries byte (j - base) of the access
  always_comb begin
    logic [REG_AW-1:0] roff;
    logic [RAM_AW-1:0] aoff;
    for (int j = 0; j < LANES; j++) begin
      lane_i[j] = 2'(j) - e.addr[1:0];
      unique case (e.size)
        SZ_BYTE: lane_on[j] = (lane_i[j] == 2'd0);
        SZ_HALF: lane_on[j] = !lane_i[j][1];
        default: lane_on[j] = 1'b1;
      endcase
      roff       = e.addr[REG_AW-1:0] + REG_AW'(lane_i[j]);
      aoff       = RAM_AW'(e.addr) + RAM_AW'(lane_i[j]);
      reg_row[j] = roff[REG_AW-1:2];
      ram_row[j] = aoff[RAM_AW-1:2];
      lane_wb[j] = 8'(e.data >> {lane_i[j], 3'b000});
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      reg_we[j]    = clr_reg || (fire && e.op == OP_MEM_WR && !e.ram && lane_on[j]);
      reg_re[j]    = fire && e.op == OP_MEM_RD && !e.ram;
      reg_addr[j]  = clr_busy ? REG_RW'(clr_row) : reg_row[j];
      reg_wdata[j] = clr_busy ? 8'h00 : lane_wb[j];
      ram_we[j]    = clr_ram || (fire && e.op == OP_MEM_WR && e.ram && lane_on[j]);
      ram_re[j]    = fire && e.op == OP_MEM_RD && e.ram;
      ram_addr[j]  = clr_busy ? RAM_RW'(clr_row) : ram_row[j];
      ram_wdata[j] = clr_busy ? 8'h00 : lane_wb[j];
    end
  end

  assign bb_we    = clr_bb || (fire && e.op == OP_WR_CMD && e_cmd == BB_CMD_WRITE);
  assign bb_re    = fire && e.op == OP_WR_CMD && e_cmd == BB_CMD_READ;
  assign bb_addr  = clr_busy ? BB_AW'(clr_row) : e.data[BB_AW-1:0];
  assign bb_wdata = clr_busy ? 8'h00 : wlatch;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    wcrb_ram #(.WIDTH(8), .DEPTH(REG_ROWS)) u_reg_lane (
      .clk   (clk),
      .we    (reg_we[j]),
      .re    (reg_re[j]),
      .addr  (reg_addr[j]),
      .wdata (reg_wdata[j]),
      .rdata (reg_rdata[j])
    );
    wcrb_ram #(.WIDTH(8), .DEPTH(RAM_ROWS)) u_ram_lane (
      .clk   (clk),
      .we    (ram_we[j]),
      .re    (ram_re[j]),
      .addr  (ram_addr[j]),
      .wdata (ram_wdata[j]),
      .rdata (ram_rdata[j])
    );
  end

  wcrb_ram #(.WIDTH(8), .DEPTH(BB_REGS)) u_bb_regs (
    .clk   (clk),
    .we    (bb_we),
    .re    (bb_re),
    .addr  (bb_addr),
    .wdata (bb_wdata),
    .rdata (bb_rdata)
  );

  // Register writes happen at issue; the read latch is loaded when the
  // command leaves the read-data stage, once the store data is back.
  always_ff @(posedge clk) begin
    if (rst) begin
      power_state <= '0;
      wlatch      <= '0;
      bb_mode     <= '0;
      bb_pwr      <= '0;
      rlatch      <= '0;
    end else begin
      if (fire) begin
        unique case (e.op)
          OP_WR_PWR:    power_state[1:0] <= e.data[1:0];
          OP_WR_WLATCH: wlatch           <= e.data[7:0];
          OP_WR_MODE:   bb_mode          <= e.data[15:0] & MODE_MASK;
          OP_WR_BBP:    bb_pwr           <= e.data[15:0] & BBP_MASK;
          default: ;
        endcase
      end
      if (p_move && p_acc.op == OP_WR_CMD && p_acc.data[15:12] == BB_CMD_READ) begin
        rlatch <= bb_read_value(p_acc.data[7:0], bb_rdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (fire) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      p_acc <= e;
    end
  end

  // Result assembly
  always_comb begin
    logic [1:0] lane;
    for (int i = 0; i < LANES; i++) begin
      lane = p_acc.addr[1:0] + 2'(i);
      p_word[8*i +: 8] = p_acc.ram ? ram_rdata[lane] : reg_rdata[lane];
    end
    unique case (p_acc.rsrc)
      RS_PWR:    p_reg = power_state;
      RS_RLATCH: p_reg = {8'h00, rlatch};
      RS_MODE:   p_reg = bb_mode;
      RS_BBP:    p_reg = bb_pwr;
      default:   p_reg = '0;
    endcase
    if (p_acc.rhi) begin
      p_reg = p_reg >> 8;
    end
    unique case (p_acc.op)
      OP_MEM_RD:   p_result = p_word;
      OP_REG_RD:   p_result = {16'h0000, p_reg};
      OP_UNMAP_RD: p_result = '1;
      default:     p_result = '0;
    endcase
    p_result = p_result & size_mask(p_acc.size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_data <= p_result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

endmodule

FILE: rtl/wireless_controller_register_block_core.sv
// Top level of the wireless controller register block.
// Depends on wcrb_pkg, wcrb_if, wcrb_front, wcrb_queue and wcrb_back.
//
//   channel | dir | payload                                      | transfer when
//   --------+-----+----------------------------------------------+-----------------
//   req     | in  | operation, access_size, address, write_data  | valid && ready
//   rsp     | out | read_data                                    | valid && ready
//
// One transfer in gives exactly one transfer out, in order. Sustained rate is
// one access per cycle while rsp is ready; a request passes a queue slot, the
// store access with registered read, then the response register.
// After rst the three byte stores are zeroed by a sweep of
// max(REG_BYTES, RAM_BYTES)/4 rows, one row of every lane per cycle;
// req.ready stays low until it ends.
// A stalled rsp fills the response register, then the read-data stage, then
// the queue, after which req.ready drops; each side stalls independently.

module wireless_controller_register_block_core import wcrb_pkg::*; #(
  parameter int RAM_BYTES = RAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wcrb_req_if.sink   req,
  wcrb_rsp_if.source rsp
);

  logic busy;
  logic push_valid;
  logic push_ready;
  acc_t push_data;
  logic pop_valid;
  logic pop_ready;
  acc_t pop_data;

  // Decode: picks the space and the named register, masks write data
  wcrb_front u_front (
    .req        (req),
    .busy       (busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouples decode from execution
  wcrb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Execution: registers, byte-lane stores, baseband port, response
  wcrb_back #(.RAM_BYTES(RAM_BYTES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_data  (pop_data),
    .busy    (busy),
    .rsp     (rsp)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for wireless_controller_register_block_core.
// Depends on wcrb_pkg, the wcrb_req_if/wcrb_rsp_if interfaces and the block itself;
// a scoreboard class predicts every read result and checks the response stream.

import wcrb_pkg::*;

localparam int RAM_SIZE = RAM_BYTES_DEF;

// Bus operation and the size code the block treats as a word
localparam bit         OPN_READ    = 1'b0;
localparam bit         OPN_WRITE   = 1'b1;
localparam logic [1:0] SZ_WORD_ALT = 2'd3;

// Address bits 14:12
localparam logic [2:0] SPACE_REG0   = 3'd0;
localparam logic [2:0] SPACE_REG1   = 3'd1;
localparam logic [2:0] SPACE_UNMAP0 = 3'd2;
localparam logic [2:0] SPACE_UNMAP1 = 3'd3;
localparam logic [2:0] SPACE_RAM0   = 3'd4;
localparam logic [2:0] SPACE_RAM1   = 3'd5;
localparam logic [2:0] SPACE_REG6   = 3'd6;
localparam logic [2:0] SPACE_REG7   = 3'd7;

class access_scoreboard;
  bit [15:0]   power_state;
  bit [7:0]    bb_read_latch;
  bit [7:0]    bb_write_latch;
  bit [15:0]   bb_mode;
  bit [15:0]   bb_pwr;
  bit [7:0]    bb_regs [BB_REGS];
  bit [7:0]    reg_bytes [REG_BYTES];
  bit [7:0]    pkt_ram [RAM_SIZE];
  logic [31:0] expected_read_data [$];
  int unsigned errors;

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %08h, expected %08h", $time, what, got, want);
    errors++;
  endfunction

  function bit bb_index_rw(logic [7:0] k);
    case (k) inside
      [8'h01:8'h0C], [8'h13:8'h15], [8'h1B:8'h26], [8'h28:8'h4C],
      [8'h4E:8'h5C], [8'h62:8'h63], 8'h65, [8'h67:8'h68]: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function logic [31:0] load_bytes(bit from_ram, int unsigned base, int unsigned nbytes);
    logic [31:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < nbytes; i++) begin
      if (from_ram) v |= 32'(pkt_ram[(base + i) % RAM_SIZE]) << (8 * i);
      else          v |= 32'(reg_bytes[(base + i) % REG_BYTES]) << (8 * i);
    end
    return v;
  endfunction

  function void store_bytes(bit to_ram, int unsigned base, int unsigned nbytes,
                            logic [31:0] v);
    int unsigned i;
    for (i = 0; i < nbytes; i++) begin
      if (to_ram) pkt_ram[(base + i) % RAM_SIZE] = v[8*i +: 8];
      else        reg_bytes[(base + i) % REG_BYTES] = v[8*i +: 8];
    end
  endfunction

  function void bb_command(logic [31:0] v);
    logic [7:0] k;
    logic [3:0] opc;
    k   = v[7:0];
    opc = v[15:12];
    if (opc == BB_CMD_WRITE) bb_regs[k] = bb_write_latch;
    else if (opc == BB_CMD_READ) begin
      if (k == BB_IDX_ID)      bb_read_latch = BB_VAL_ID;
      else if (k == BB_IDX_4D) bb_read_latch = BB_VAL_4D;
      else if (k == BB_IDX_5D) bb_read_latch = BB_VAL_5D;
      else if (k == BB_IDX_64) bb_read_latch = BB_VAL_64;
      else if (bb_index_rw(k)) bb_read_latch = bb_regs[k];
      else                     bb_read_latch = 8'h00;
    end
  endfunction

  function logic [31:0] reg_load(logic [11:0] off, int unsigned nbytes);
    if (nbytes == 1) begin
      case (off)
        OFF_PWR:       return 32'(power_state[7:0]);
        OFF_PWR_HI:    return 32'(power_state[15:8]);
        OFF_BB_RLATCH: return 32'(bb_read_latch);
        OFF_BB_RL_B1, OFF_BB_RL_B2, OFF_BB_RL_B3: return '0;
        OFF_BB_MODE:   return 32'(bb_mode[7:0]);
        OFF_BB_MODE_H: return 32'(bb_mode[15:8]);
        OFF_BB_POWER:  return 32'(bb_pwr[7:0]);
        OFF_BB_POW_H:  return 32'(bb_pwr[15:8]);
        default: ;
      endcase
    end else if (nbytes == 2) begin
      case (off)
        OFF_PWR:       return 32'(power_state);
        OFF_BB_RLATCH: return 32'(bb_read_latch);
        OFF_BB_RL_B2:  return '0;
        OFF_BB_MODE:   return 32'(bb_mode);
        OFF_BB_POWER:  return 32'(bb_pwr);
        default: ;
      endcase
    end else if (off == OFF_PWR) begin
      return 32'(power_state);
    end
    return load_bytes(1'b0, off, nbytes);
  endfunction

  function void reg_write(logic [11:0] off, int unsigned nbytes, logic [31:0] v);
    if (off == OFF_PWR) begin
      power_state[1:0] = v[1:0];
      return;
    end
    if (nbytes == 2) begin
      case (off)
        OFF_BB_CMD:    begin bb_command(v); return; end
        OFF_BB_WLATCH: begin bb_write_latch = v[7:0]; return; end
        OFF_BB_MODE:   begin bb_mode = v[15:0] & MODE_MASK; return; end
        OFF_BB_POWER:  begin bb_pwr = v[15:0] & BBP_MASK; return; end
        default: ;
      endcase
    end
    store_bytes(1'b0, off, nbytes, v);
  endfunction

  // One bus access: updates the mirrored state, returns the read data it yields
  function logic [31:0] bus_access(bit wr, logic [1:0] sz, logic [14:0] a, logic [31:0] d);
    int unsigned nbytes;
    logic [31:0] szmask;
    logic [31:0] res;
    logic [2:0]  sp;
    bit          in_regs;
    bit          in_ram;
    nbytes  = (sz == SZ_BYTE) ? 1 : (sz == SZ_HALF) ? 2 : 4;
    szmask  = (nbytes == 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * nbytes)) - 32'd1;
    sp      = a[14:12];
    in_regs = (sp == SPACE_REG0) || (sp == SPACE_REG1) || (sp == SPACE_REG6) ||
              (sp == SPACE_REG7);
    in_ram  = (sp == SPACE_RAM0) || (sp == SPACE_RAM1);
    res     = '0;
    if (wr) begin
      if (nbytes != 1) begin
        d &= szmask;
        if (in_regs)     reg_write(a[11:0], nbytes, d);
        else if (in_ram) store_bytes(1'b1, a % RAM_SIZE, nbytes, d);
      end
    end else begin
      if (in_regs)     res = reg_load(a[11:0], nbytes);
      else if (in_ram) res = load_bytes(1'b1, a % RAM_SIZE, nbytes);
      else             res = szmask;
      res &= szmask;
    end
    return res;
  endfunction

  function void note_access(bit wr, logic [1:0] sz, logic [14:0] a, logic [31:0] d);
    expected_read_data.push_back(bus_access(wr, sz, a, d));
  endfunction

  function void check_response(logic [31:0] got);
    logic [31:0] want;
    if (expected_read_data.size() == 0) begin
      report("response with no access outstanding", got, 'x);
      return;
    end
    want = expected_read_data.pop_front();
    if (got !== want) report("read_data mismatch", got, want);
  endfunction

  function int unsigned pending();
    return expected_read_data.size();
  endfunction
endclass

module tb_top;

  // Timing of the run
  localparam int unsigned IDLE_PCT     = 23;     // per cent of cycles a side idles
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned QUIET_FROM   = 400;    // random items with no idling at all
  localparam int unsigned QUIET_TO     = 560;
  localparam int unsigned HOLD_AT      = 300;    // accepted transfers before the long stall
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 12;     // wait after the last response, for strays
  localparam int unsigned CYCLE_LIMIT  = 200000; // sweep + items, many times over

  logic clk;
  logic rst;

  wcrb_req_if req_ch ();
  wcrb_rsp_if rsp_ch ();

  wireless_controller_register_block_core #(
    .RAM_BYTES(RAM_SIZE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  access_scoreboard sb = new;

  int unsigned accepted;
  int unsigned idle_pct;
  int unsigned cycles;
  bit          hold_pending;

  // Named register offsets, for random hits on the special decode
  logic [11:0] named_offs [12] = '{OFF_PWR, OFF_PWR_HI, OFF_BB_CMD, OFF_BB_WLATCH,
                                   OFF_BB_RLATCH, OFF_BB_RL_B1, OFF_BB_RL_B2,
                                   OFF_BB_RL_B3, OFF_BB_MODE, OFF_BB_MODE_H,
                                   OFF_BB_POWER, OFF_BB_POW_H};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** wireless_controller_register_block_core: FAILED **");
    $finish;
  end

  // Monitor: every request transfer feeds the predictor, every response transfer is
  // checked against the oldest prediction. Sampled at the rising edge, so both
  // see the values the block saw.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_access(req_ch.operation, req_ch.access_size, req_ch.address,
                     req_ch.write_data);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.read_data);
  end

  // Response side. Random back-pressure, and once a long hold-off so the
  // response register, read stage and queue all fill and req.ready drops.
  initial begin : rsp_sink
    int unsigned held;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ch.ready = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
      end
      rsp_ch.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // Offer one access at the falling edge and wait for its transfer. Valid stays
  // high between back-to-back items; it only drops for an idle cycle.
  task automatic send_access(input bit wr, input logic [1:0] sz, input logic [14:0] a,
                             input logic [31:0] d);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.operation   = wr;
    req_ch.access_size = sz;
    req_ch.address     = a;
    req_ch.write_data  = d;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    accepted++;
    if (accepted == HOLD_AT) hold_pending = 1'b1;
  endtask

  // Mostly the three real sizes, now and then the code the block folds into word
  function automatic logic [1:0] rand_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return SZ_WORD_ALT;
    return 2'(r % 3);
  endfunction

  // Register offset placed in one of the four mirrored spaces
  function automatic logic [14:0] reg_addr(input logic [11:0] off);
    logic [2:0] sp;
    case ($urandom_range(3))
      0:       sp = SPACE_REG0;
      1:       sp = SPACE_REG1;
      2:       sp = SPACE_REG6;
      default: sp = SPACE_REG7;
    endcase
    return {sp, off};
  endfunction

  initial begin : stimulus
    int unsigned rand_done;
    int unsigned pick;
    logic [7:0]  idx;
    logic [11:0] off;
    logic [12:0] roff;
    logic [1:0]  sz;

    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OPN_READ;
    req_ch.access_size = SZ_BYTE;
    req_ch.address     = '0;
    req_ch.write_data  = '0;
    accepted           = 0;
    hold_pending       = 1'b0;
    idle_pct           = IDLE_PCT;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset values, unmapped space, each named register, ignored
    // byte writes, packet RAM wrap, size code three
    send_access(OPN_READ,  SZ_WORD, 15'h0000, '0);
    send_access(OPN_READ,  SZ_BYTE, 15'h2000, '0);
    send_access(OPN_READ,  SZ_WORD, 15'h3FFC, '0);
    send_access(OPN_WRITE, SZ_WORD, {SPACE_REG0, OFF_PWR}, 32'hFFFF_FFFF);
    send_access(OPN_READ,  SZ_HALF, {SPACE_REG1, OFF_PWR}, '0);
    send_access(OPN_WRITE, SZ_HALF, {SPACE_REG6, OFF_BB_WLATCH}, 32'hFFFF_FFA5);
    send_access(OPN_WRITE, SZ_HALF, {SPACE_REG7, OFF_BB_CMD}, {16'h0, BB_CMD_WRITE, 12'h028});
    send_access(OPN_WRITE, SZ_HALF, {SPACE_REG0, OFF_BB_CMD}, {16'h0, BB_CMD_READ, 12'h028});
    send_access(OPN_READ,  SZ_BYTE, {SPACE_REG0, OFF_BB_RLATCH}, '0);
    send_access(OPN_WRITE, SZ_HALF, {SPACE_REG0, OFF_BB_CMD}, {16'h0, BB_CMD_READ, 4'h0, BB_IDX_ID});
    send_access(OPN_READ,  SZ_HALF, {SPACE_REG0, OFF_BB_RLATCH}, '0);
    send_access(OPN_WRITE, SZ_HALF, {SPACE_REG0, OFF_BB_MODE}, 32'hFFFF_FFFF);
    send_access(OPN_READ,  SZ_BYTE, {SPACE_REG0, OFF_BB_MODE_H}, '0);
    send_access(OPN_WRITE, SZ_HALF, {SPACE_REG0, OFF_BB_POWER}, 32'hFFFF_FFFF);
    send_access(OPN_READ,  SZ_HALF, {SPACE_REG1, OFF_BB_POWER}, '0);
    send_access(OPN_WRITE, SZ_BYTE, 15'h0200, 32'hFFFF_FFFF);
    send_access(OPN_READ,  SZ_WORD, 15'h0200, '0);
    send_access(OPN_WRITE, SZ_WORD, 15'h4000, 32'hDEAD_BEEF);
    send_access(OPN_READ,  SZ_HALF, 15'h4002, '0);
    send_access(OPN_WRITE, SZ_WORD, 15'h5FFE, 32'h1234_5678);  // wraps to RAM start
    send_access(OPN_READ,  SZ_WORD, 15'h4000, '0);
    send_access(OPN_WRITE, SZ_WORD, 15'h2000, 32'hFFFF_FFFF);  // unmapped, dropped
    send_access(OPN_READ,  SZ_WORD_ALT, 15'h7FFF, '0);          // wraps in register store
    send_access(OPN_WRITE, SZ_WORD, {SPACE_REG0, OFF_BB_CMD}, 32'hFFFF_6028);
    send_access(OPN_READ,  SZ_WORD, {SPACE_REG0, OFF_BB_CMD}, '0);

    // Random part
    rand_done = 0;
    while (rand_done < RANDOM_ITEMS) begin
      idle_pct = (rand_done >= QUIET_FROM && rand_done < QUIET_TO) ? 0 : IDLE_PCT;
      pick = $urandom_range(99);
      if (pick < 20) begin
        // Serial port sequence: load write latch, mostly write register, read it back
        pick = $urandom_range(99);
        if (pick < 25) begin
          case ($urandom_range(3))
            0:       idx = BB_IDX_ID;
            1:       idx = BB_IDX_4D;
            2:       idx = BB_IDX_5D;
            default: idx = BB_IDX_64;
          endcase
        end else if (pick < 70) idx = 8'($urandom_range(8'h6F));
        else                    idx = 8'($urandom);
        send_access(OPN_WRITE, SZ_HALF, reg_addr(OFF_BB_WLATCH), $urandom);
        if ($urandom_range(9) < 7)
          send_access(OPN_WRITE, SZ_HALF, reg_addr(OFF_BB_CMD),
                      {16'($urandom), BB_CMD_WRITE, 4'($urandom), idx});
        send_access(OPN_WRITE, SZ_HALF, reg_addr(OFF_BB_CMD),
                    {16'($urandom), BB_CMD_READ, 4'($urandom), idx});
        send_access(OPN_READ, $urandom_range(1) ? SZ_HALF : SZ_BYTE,
                    reg_addr(OFF_BB_RLATCH), $urandom);
        rand_done += 4;
      end else if (pick < 45) begin
        send_access(bit'($urandom_range(1)), rand_size(),
                    reg_addr(named_offs[$urandom_range(11)]), $urandom);
        rand_done++;
      end else if (pick < 65) begin
        // Small generic window so reads land on earlier writes
        sz  = rand_size();
        off = 12'h200 + {6'($urandom_range(15)), 2'b00};
        pick = $urandom_range(9);
        if (pick == 0)      off = 12'hFFC + 12'($urandom_range(3));
        else if (pick == 1) off = off + 12'($urandom_range(1, 3));
        send_access(bit'($urandom_range(1)), sz, reg_addr(off), $urandom);
        rand_done++;
      end else if (pick < 85) begin
        // Packet RAM, both ends of the array
        sz   = rand_size();
        roff = 13'({$urandom_range(15), 2'b00});
        if ($urandom_range(1)) roff = roff + 13'(RAM_SIZE - 64);
        if ($urandom_range(9) == 0) roff = roff + 13'($urandom_range(1, 3));
        send_access(bit'($urandom_range(1)), sz, {SPACE_RAM0[2:1], roff}, $urandom);
        rand_done++;
      end else if (pick < 93) begin
        send_access(bit'($urandom_range(1)), rand_size(), 15'($urandom), $urandom);
        rand_done++;
      end else begin
        send_access(bit'($urandom_range(1)), rand_size(),
                    {$urandom_range(1) ? SPACE_UNMAP1 : SPACE_UNMAP0, 12'($urandom)},
                    $urandom);
        rand_done++;
      end
    end

    @(negedge clk);
    req_ch.valid = 1'b0;

    // Drain, then wait DRAIN_CYCLES more to catch any stray response
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("** wireless_controller_register_block_core: PASSED **");
    else
      $display("** wireless_controller_register_block_core: FAILED **");
    $finish;
  end

endmodule
